>>> rtl/flc_pkg.sv
// Package for the FIFO line cache lookup block.
// Holds sizes, register and command codes, and the controller/datapath types.
// No dependencies; every other file in rtl but flc_ram imports it.
package flc_pkg;

	localparam int MAX_PACKETS    = 4096;
	localparam int MAX_LINES_HELD = 16;
	localparam int OFFSET_BITS    = 48;

	localparam int IDX_W   = 13;
	localparam int LINE_W  = 12;
	localparam int SLOT_W  = 4;
	localparam int FILL_W  = 5;
	localparam int LB_W    = 4;
	localparam int TAB_DEPTH = MAX_PACKETS + 1;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 224;
	localparam int OUT_TUSER_W = 4;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	// register word indexes (paddr[3:2])
	localparam logic [1:0] REG_LINE_BITS   = 2'd0;
	localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
	localparam logic [1:0] REG_NUM_DATA    = 2'd2;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAG,
		ST_RBASE,
		ST_REND,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		ADDR_IN,
		ADDR_IDX1,
		ADDR_BASE,
		ADDR_END
	} addr_sel_t;

	typedef struct packed {
		logic [LB_W-1:0]   line_bits;
		logic [FILL_W-1:0] max_entries;
		logic [IDX_W-1:0]  num_data;
	} cfg_t;

	typedef struct packed {
		logic      latch;
		logic      re;
		addr_sel_t addr_sel;
		logic      tag;
		logic      cap_b;
		logic      cap_base;
		logic      load;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/flc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Does not use flc_pkg; parameters set width and depth.
module flc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/flc_regs.sv
// APB configuration registers: line_bits, max_entries, num_data.
// Depends on flc_pkg; raises flush on every write to a defined register.
module flc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [flc_pkg::APB_AW-1:0] paddr,
	input  logic [flc_pkg::APB_DW-1:0] pwdata,
	output logic [flc_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output flc_pkg::cfg_t              cfg,
	output logic                       flush
);
	import flc_pkg::*;

	logic [LB_W-1:0]   line_bits_q;
	logic [FILL_W-1:0] max_entries_q;
	logic [IDX_W-1:0]  num_data_q;
	logic              wr;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bits_q   <= '0;
			max_entries_q <= FILL_W'(MAX_LINES_HELD);
			num_data_q    <= '0;
		end else if (wr) begin
			unique case (reg_idx)
				REG_LINE_BITS:   line_bits_q   <= pwdata[LB_W-1:0];
				REG_MAX_ENTRIES: max_entries_q <= pwdata[FILL_W-1:0];
				REG_NUM_DATA:    num_data_q    <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		flush = 1'b0;
		if (wr) begin
			flush = (reg_idx == REG_LINE_BITS) || (reg_idx == REG_MAX_ENTRIES) ||
				(reg_idx == REG_NUM_DATA);
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LINE_BITS:   prdata = APB_DW'(line_bits_q);
			REG_MAX_ENTRIES: prdata = APB_DW'(max_entries_q);
			REG_NUM_DATA:    prdata = APB_DW'(num_data_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.line_bits   = line_bits_q;
	assign cfg.max_entries = max_entries_q;
	assign cfg.num_data    = num_data_q;

endmodule

>>> rtl/flc_ctrl.sv
// Controller for the line cache lookup: sequences the four table reads.
// Depends on flc_pkg; drives datapath commands, reads datapath status.
module flc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_command,
	output logic           in_ready,
	input  flc_pkg::stat_t stat,
	output flc_pkg::cmd_t  cmd
);
	import flc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_command == CMD_LOOKUP) begin
					state_d = ST_TAG;
				end
			end
			ST_TAG:   state_d = stat.err ? ST_FIN : ST_RBASE;
			ST_RBASE: state_d = ST_REND;
			ST_REND:  state_d = ST_FIN;
			ST_FIN: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.latch    = 1'b0;
		cmd.re       = 1'b0;
		cmd.addr_sel = ADDR_IN;
		cmd.tag      = 1'b0;
		cmd.cap_b    = 1'b0;
		cmd.cap_base = 1'b0;
		cmd.load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid && in_command == CMD_LOOKUP;
				cmd.re    = cmd.latch;
			end
			ST_TAG: begin
				cmd.re       = 1'b1;
				cmd.addr_sel = ADDR_IDX1;
				cmd.tag      = 1'b1;
			end
			ST_RBASE: begin
				cmd.re       = 1'b1;
				cmd.addr_sel = ADDR_BASE;
				cmd.cap_b    = 1'b1;
			end
			ST_REND: begin
				cmd.re       = 1'b1;
				cmd.addr_sel = ADDR_END;
				cmd.cap_base = 1'b1;
			end
			ST_FIN: begin
				// hold the end-of-line word in the RAM output until the result loads
				cmd.load = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/flc_dp.sv
// Datapath: offset table RAM, slot tags with FIFO victim pointer, result register.
// Depends on flc_pkg and flc_ram; steered by flc_ctrl commands.
module flc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  flc_pkg::cfg_t                   cfg,
	input  logic                            flush,
	input  flc_pkg::cmd_t                   cmd,
	output flc_pkg::stat_t                  stat,
	input  logic                            in_accept,
	input  logic                            in_command,
	input  logic [flc_pkg::IDX_W-1:0]       in_index,
	input  logic [flc_pkg::OFFSET_BITS-1:0] in_offset,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [flc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [flc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import flc_pkg::*;

	localparam int TAB_AW = $clog2(TAB_DEPTH);

	// lookup setup, computed from the input word at acceptance
	logic [IDX_W-1:0]  nd_w;
	logic [IDX_W-1:0]  base_w;
	logic [16:0]       lsize_w;
	logic [16:0]       sum_w;
	logic [IDX_W-1:0]  end_w;
	logic [FILL_W-1:0] maxe_w;

	logic              err_q;
	logic [LINE_W-1:0] idx_q;
	logic [LINE_W-1:0] line_q;
	logic [LINE_W-1:0] base_q;
	logic [IDX_W-1:0]  end_q;

	// slot tags
	logic [LINE_W-1:0] slot_line_q [MAX_LINES_HELD];
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] victim_q;
	logic              cam_hit;
	logic [SLOT_W-1:0] cam_slot;
	logic              full_w;
	logic [SLOT_W-1:0] new_slot;
	logic              insert;

	logic              hit_q;
	logic              evict_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LINE_W-1:0] evicted_q;

	logic [OFFSET_BITS-1:0] a_q;
	logic [OFFSET_BITS-1:0] b_q;
	logic [OFFSET_BITS-1:0] bv_q;

	logic                   ram_we;
	logic [TAB_AW-1:0]      ram_raddr;
	logic [OFFSET_BITS-1:0] ram_rdata;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic [OUT_TUSER_W-1:0] out_tuser_q;

	assign nd_w    = (cfg.num_data > IDX_W'(MAX_PACKETS)) ? IDX_W'(MAX_PACKETS) : cfg.num_data;
	assign lsize_w = 17'd1 << cfg.line_bits;
	assign base_w  = in_index & ({IDX_W{1'b1}} << cfg.line_bits);
	assign sum_w   = 17'(base_w) + lsize_w;
	assign end_w   = (sum_w > 17'(nd_w)) ? nd_w : sum_w[IDX_W-1:0];

	always_comb begin
		if (cfg.max_entries == '0) begin
			maxe_w = FILL_W'(1);
		end else if (cfg.max_entries > FILL_W'(MAX_LINES_HELD)) begin
			maxe_w = FILL_W'(MAX_LINES_HELD);
		end else begin
			maxe_w = cfg.max_entries;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			idx_q  <= in_index[LINE_W-1:0];
			line_q <= LINE_W'(in_index >> cfg.line_bits);
			base_q <= base_w[LINE_W-1:0];
			end_q  <= end_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (cmd.latch) begin
			err_q <= in_index >= nd_w;
		end
	end

	assign stat.err = err_q;

	// offset table
	assign ram_we = in_accept && in_command == CMD_WRITE && in_index <= IDX_W'(MAX_PACKETS);

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_IN:   ram_raddr = TAB_AW'(in_index);
			ADDR_IDX1: ram_raddr = TAB_AW'(idx_q) + TAB_AW'(1);
			ADDR_BASE: ram_raddr = TAB_AW'(base_q);
			ADDR_END:  ram_raddr = TAB_AW'(end_q);
			default:   ram_raddr = '0;
		endcase
	end

	flc_ram #(
		.WIDTH(OFFSET_BITS),
		.DEPTH(TAB_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(TAB_AW'(in_index)),
		.wdata(in_offset),
		.re   (cmd.re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// tag compare across all filled slots
	always_comb begin
		cam_hit  = 1'b0;
		cam_slot = '0;
		for (int s = 0; s < MAX_LINES_HELD; s++) begin
			if (FILL_W'(s) < fill_q && slot_line_q[s] == line_q) begin
				cam_hit  = 1'b1;
				cam_slot = SLOT_W'(s);
			end
		end
	end

	assign full_w   = fill_q >= maxe_w;
	assign new_slot = full_w ? victim_q : fill_q[SLOT_W-1:0];
	assign insert   = cmd.tag && !err_q && !cam_hit;

	always_ff @(posedge clk) begin
		if (insert) begin
			slot_line_q[new_slot] <= line_q;
		end
		if (cmd.tag) begin
			hit_q     <= cam_hit;
			evict_q   <= !cam_hit && full_w;
			slot_q    <= cam_hit ? cam_slot : new_slot;
			evicted_q <= slot_line_q[victim_q];
			a_q       <= ram_rdata;
		end
		if (cmd.cap_b) begin
			b_q <= ram_rdata;
		end
		if (cmd.cap_base) begin
			bv_q <= ram_rdata;
		end
	end

	// slots fill in order, then the victim pointer walks them round robin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			victim_q <= '0;
		end else if (flush) begin
			fill_q   <= '0;
			victim_q <= '0;
		end else if (insert) begin
			if (full_w) begin
				if (FILL_W'(victim_q) + FILL_W'(1) == maxe_w) begin
					victim_q <= '0;
				end else begin
					victim_q <= victim_q + SLOT_W'(1);
				end
			end else begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// result register
	assign stat.out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (err_q) begin
				out_tdata_q <= '0;
				out_tuser_q <= 4'b1000;
			end else begin
				out_tdata_q <= {
					4'b0000,
					b_q - a_q,
					a_q - bv_q,
					evict_q ? evicted_q : LINE_W'(0),
					hit_q ? OFFSET_BITS'(0) : ram_rdata - bv_q,
					hit_q ? OFFSET_BITS'(0) : bv_q,
					line_q,
					slot_q
				};
				out_tuser_q <= {1'b0, evict_q, !hit_q, hit_q};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;

`ifndef NO_ASSERTIONS
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> fill_q == '0 && victim_q == '0)
		else $error("cache not emptied after register write");

	a_hit_keeps_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tag && cam_hit && !flush |=> $stable(fill_q) && $stable(victim_q))
		else $error("hit changed fill count or victim pointer");

	a_victim_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		victim_q != '0 |-> fill_q == maxe_w)
		else $error("victim pointer moved before cache filled");
`endif

endmodule

>>> rtl/fifo_line_cache_lookup_top.sv
// Top level of the FIFO-replacement line cache lookup.
// Depends on flc_pkg, flc_regs, flc_ctrl, flc_dp (which holds flc_ram).
//
// Usage:
//  Input stream (s_axis_*): tuser is the command, 0 writes an offset table
//  entry, 1 looks up a packet. tdata carries index and byte offset.
//  Output stream (m_axis_*): one word per lookup, none per table write.
//  APB port: line_bits at 0x0, max_entries at 0x4, num_data at 0x8. A write
//  to any of them also empties the cache. Write registers only while idle.
//  Flow: a table write is taken every cycle while no lookup is busy. A
//  lookup's result is loaded into the result register before the next input
//  word is taken; a lookup with an index at or beyond num_data skips the line reads.
//  Lookups are paced by the four serial reads (packet, next packet, line
//  start, line end) through the single read port of the offset table RAM.
//  The result register lets the next word in while a result waits; if the
//  receiver stalls, the following lookup holds in its last step until the
//  register frees. Reset empties the cache and the result register and sets
//  line_bits 0, max_entries 16, num_data 0; the offset table is not cleared.
module fifo_line_cache_lookup_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [12:0] index, [60:13] offset_value, [63:61] zero
	input  logic [flc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [3:0] slot, [15:4] line_number, [63:16] fetch_offset, [111:64] fetch_size,
	// [123:112] evicted_line, [171:124] local_offset, [219:172] data_size
	output logic [flc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] hit, [1] fetch, [2] evict_valid, [3] index_error
	output logic [flc_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [flc_pkg::APB_AW-1:0]      paddr,
	input  logic [flc_pkg::APB_DW-1:0]      pwdata,
	output logic [flc_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);
	import flc_pkg::*;

	cfg_t  cfg;
	logic  flush;
	cmd_t  cmd;
	stat_t stat;
	logic  in_accept;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	flc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.flush  (flush)
	);

	flc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_command(s_axis_tuser),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	flc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.flush        (flush),
		.cmd          (cmd),
		.stat         (stat),
		.in_accept    (in_accept),
		.in_command   (s_axis_tuser),
		.in_index     (s_axis_tdata[IDX_W-1:0]),
		.in_offset    (s_axis_tdata[IDX_W+OFFSET_BITS-1:IDX_W]),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

>>> tb/fifo_line_cache_lookup_top_tb.sv
// Self-checking testbench for fifo_line_cache_lookup_top.
// Drives table writes and lookups on the input stream, predicts every result word
// and compares it field by field. Needs flc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module fifo_line_cache_lookup_top_tb;
	import flc_pkg::*;

	localparam int CMD_RING = 4096;
	localparam int EXP_RING = 64;

	typedef struct {
		logic              cmd;
		logic [IDX_W-1:0]  index;
		logic [47:0]       ofs;
	} table_cmd_t;

	typedef struct packed {
		logic              hit;
		logic              fetch;
		logic [SLOT_W-1:0] slot;
		logic [LINE_W-1:0] line_number;
		logic [47:0]       fetch_offset;
		logic [47:0]       fetch_size;
		logic              evict_valid;
		logic [LINE_W-1:0] evicted_line;
		logic [47:0]       local_offset;
		logic [47:0]       data_size;
		logic              index_error;
	} lookup_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   psel    = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite  = 1'b0;
	logic [APB_AW-1:0]      paddr   = '0;
	logic [APB_DW-1:0]      pwdata  = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	fifo_line_cache_lookup_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// predictor state
	logic [47:0]       ofs_tab      [0:MAX_PACKETS];
	bit                line_res     [0:MAX_PACKETS-1];
	logic [SLOT_W-1:0] line_slot_of [0:MAX_PACKETS-1];
	logic [LINE_W-1:0] fifo_q       [0:MAX_LINES_HELD-1];
	int unsigned       fifo_hd  = 0;
	int unsigned       fifo_cnt = 0;
	logic [LB_W-1:0]   cfg_lb   = '0;
	logic [FILL_W-1:0] cfg_maxe = 5'd16;
	logic [IDX_W-1:0]  cfg_nd   = '0;

	// pending input words and expected result words, as rings
	table_cmd_t     cmd_ring[CMD_RING];
	int             cmd_wr = 0;
	int             cmd_rd = 0;
	lookup_result_t exp_ring[EXP_RING];
	int             exp_wr = 0;
	int             exp_rd = 0;
	bit             table_filled[0:MAX_PACKETS];
	int             cmds_in_flight = 0;
	int             items_pushed   = 0;
	int             mismatches     = 0;
	int             send_idle_pct  = 0;
	int             recv_idle_pct  = 0;
	int             hold_reqs      = 0;
	int             holds_served   = 0;
	int             rx_hold_left   = 0;

	// stimulus shape of the current phase
	int cur_nd;
	int cur_lb;
	int hot_lines[MAX_LINES_HELD+1];
	int hot_cnt = 0;

	// random phases: line_bits, max_entries, num_data, item count
	int ph_lb   [9] = '{0, 3, 15, 6, 1, 2, 0, 4, 0};
	int ph_maxe [9] = '{4, 16, 0, 3, 1, 31, 16, 5, 16};
	int ph_nd   [9] = '{40, 300, 8191, 4096, 1, 100, 0, 2000, 4096};
	int ph_items[9] = '{180, 150, 150, 150, 100, 150, 60, 150, 250};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic lookup_result_t lookup_packet(logic [IDX_W-1:0] idx);
		lookup_result_t r;
		int unsigned ix, nd, maxe, lsize, line_no, base, fin, slot, old;
		logic [47:0] a;
		r = '0;
		ix = idx;
		nd = (cfg_nd > MAX_PACKETS) ? MAX_PACKETS : cfg_nd;
		if (ix >= nd) begin
			r.index_error = 1'b1;
			return r;
		end
		maxe = (cfg_maxe < 1) ? 1 : ((cfg_maxe > MAX_LINES_HELD) ? MAX_LINES_HELD : cfg_maxe);
		lsize = 1 << cfg_lb;
		line_no = ix >> cfg_lb;
		base = ix & ~(lsize - 1);
		if (line_res[line_no]) begin
			slot = line_slot_of[line_no];
			r.hit = 1'b1;
		end else begin
			// full: retire the oldest line and reuse its slot
			if (fifo_cnt >= maxe) begin
				old = fifo_q[fifo_hd];
				slot = line_slot_of[old];
				line_res[old] = 1'b0;
				fifo_hd = (fifo_hd + 1) % MAX_LINES_HELD;
				fifo_cnt--;
				r.evict_valid = 1'b1;
				r.evicted_line = LINE_W'(old);
			end else begin
				slot = fifo_cnt;
			end
			fifo_q[(fifo_hd + fifo_cnt) % MAX_LINES_HELD] = LINE_W'(line_no);
			fifo_cnt++;
			line_res[line_no] = 1'b1;
			line_slot_of[line_no] = SLOT_W'(slot);
			fin = base + lsize;
			if (fin > nd)
				fin = nd;
			r.fetch = 1'b1;
			r.fetch_offset = ofs_tab[base];
			r.fetch_size = ofs_tab[fin] - ofs_tab[base];
		end
		r.slot = SLOT_W'(slot);
		r.line_number = LINE_W'(line_no);
		a = ofs_tab[ix];
		r.local_offset = a - ofs_tab[base];
		r.data_size = ofs_tab[ix + 1] - a;
		return r;
	endfunction

	function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [47:0] rand_ofs();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic void queue_cmd(table_cmd_t c);
		cmd_ring[cmd_wr % CMD_RING] = c;
		cmd_wr++;
		cmds_in_flight++;
		items_pushed++;
	endfunction

	function automatic void push_write(int idx, logic [47:0] v);
		table_cmd_t c;
		c.cmd = CMD_WRITE;
		c.index = idx[IDX_W-1:0];
		c.ofs = v;
		if (idx <= MAX_PACKETS)
			table_filled[idx] = 1'b1;
		queue_cmd(c);
	endfunction

	function automatic void push_lookup(int idx);
		table_cmd_t c;
		c.cmd = CMD_LOOKUP;
		c.index = idx[IDX_W-1:0];
		c.ofs = rand_ofs();
		queue_cmd(c);
	endfunction

	// a lookup reads its own entry, the next one, the line start and the line end
	function automatic void need_entry(int k);
		if (!table_filled[k])
			push_write(k, rand_ofs());
	endfunction

	// mostly lookups that revisit a small set of lines, some table writes and bad indexes
	function automatic void push_random_cmds(int n);
		int r, lsize, nlines, line_no, idx, base, fin, start;
		lsize = 1 << cur_lb;
		nlines = (cur_nd + lsize - 1) >> cur_lb;
		start = items_pushed;
		while (items_pushed - start < n) begin
			r = $urandom_range(99);
			if (r < 20) begin
				idx = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(MAX_PACKETS);
				push_write(idx, rand_ofs());
			end else if (r < 30 || cur_nd == 0) begin
				push_lookup($urandom_range(8191, cur_nd));
			end else begin
				if ($urandom_range(99) < 65)
					line_no = hot_lines[$urandom_range(hot_cnt - 1)];
				else
					line_no = $urandom_range(nlines - 1);
				idx = (line_no << cur_lb) + $urandom_range(lsize - 1);
				if (idx >= cur_nd)
					idx = cur_nd - 1;
				base = idx & ~(lsize - 1);
				fin = base + lsize;
				if (fin > cur_nd)
					fin = cur_nd;
				need_entry(idx);
				need_entry(idx + 1);
				need_entry(base);
				need_entry(fin);
				push_lookup(idx);
			end
		end
	endfunction

	task automatic wait_idle();
		while (cmds_in_flight != 0 || exp_wr != exp_rd)
			@(posedge clk);
		// table writes leave no result; let the last one settle
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] reg_idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			REG_LINE_BITS:   cfg_lb = val[LB_W-1:0];
			REG_MAX_ENTRIES: cfg_maxe = val[FILL_W-1:0];
			REG_NUM_DATA:    cfg_nd = val[IDX_W-1:0];
			default: ;
		endcase
		// any register write empties the cache
		for (int k = 0; k < MAX_PACKETS; k++) begin
			line_res[k] = 1'b0;
			line_slot_of[k] = '0;
		end
		fifo_hd = 0;
		fifo_cnt = 0;
	endtask

	// driver: present the next queued word, predict on acceptance
	always @(posedge clk) begin : drive
		table_cmd_t on_bus;
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (s_axis_tvalid) begin
				if (on_bus.cmd == CMD_WRITE) begin
					if (on_bus.index <= MAX_PACKETS)
						ofs_tab[on_bus.index] = on_bus.ofs;
				end else begin
					exp_ring[exp_wr % EXP_RING] = lookup_packet(on_bus.index);
					exp_wr++;
				end
				cmds_in_flight--;
			end
			if (cmd_wr != cmd_rd && $urandom_range(99) >= send_idle_pct) begin
				on_bus = cmd_ring[cmd_rd % CMD_RING];
				cmd_rd++;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {3'b000, on_bus.ofs, on_bus.index};
				s_axis_tuser  <= on_bus.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compare each result word, throttle tready
	always @(posedge clk) begin : watch
		lookup_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_wr == exp_rd) begin
					$error("result word with no lookup outstanding");
					mismatches++;
				end else begin
					want = exp_ring[exp_rd % EXP_RING];
					exp_rd++;
					check_field("hit", 48'(want.hit), 48'(m_axis_tuser[0]));
					check_field("fetch", 48'(want.fetch), 48'(m_axis_tuser[1]));
					check_field("evict_valid", 48'(want.evict_valid), 48'(m_axis_tuser[2]));
					check_field("index_error", 48'(want.index_error), 48'(m_axis_tuser[3]));
					check_field("slot", 48'(want.slot), 48'(m_axis_tdata[3:0]));
					check_field("line_number", 48'(want.line_number), 48'(m_axis_tdata[15:4]));
					check_field("fetch_offset", want.fetch_offset, m_axis_tdata[63:16]);
					check_field("fetch_size", want.fetch_size, m_axis_tdata[111:64]);
					check_field("evicted_line", 48'(want.evicted_line),
						48'(m_axis_tdata[123:112]));
					check_field("local_offset", want.local_offset, m_axis_tdata[171:124]);
					check_field("data_size", want.data_size, m_axis_tdata[219:172]);
				end
			end
			if (holds_served != hold_reqs) begin
				holds_served++;
				rx_hold_left = 600;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int lsize, nlines, maxe;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 14;
		recv_idle_pct = 51;

		// reset settings: num_data is zero, so any lookup is out of range
		push_lookup(0);
		push_write(MAX_PACKETS, rand_ofs());
		wait_idle();

		// two-packet lines, two slots, five packets: last line is clipped
		reg_write(REG_LINE_BITS, 32'd1);
		reg_write(REG_MAX_ENTRIES, 32'd2);
		reg_write(REG_NUM_DATA, 32'd5);
		push_write(0, 48'd0);
		push_write(1, 48'd100);
		push_write(2, 48'd250);
		push_write(3, 48'hFFFF_FFFF_FFFF);
		push_write(4, 48'd40);
		push_write(5, 48'd1000);
		push_write(8191, 48'hFFFF_FFFF_FFFF);
		push_write(4097, 48'hFFFF_FFFF_FFFF);
		push_lookup(0);
		push_lookup(1);
		push_lookup(2);
		push_lookup(4);
		push_lookup(5);
		push_lookup(3);
		push_lookup(0);
		push_lookup(8191);
		push_lookup(4);

		for (int p = 0; p < 9; p++) begin
			wait_idle();
			case (p / 3)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			reg_write(REG_LINE_BITS, ($urandom & ~32'hF) | ph_lb[p]);
			reg_write(REG_MAX_ENTRIES, ($urandom & ~32'h1F) | ph_maxe[p]);
			reg_write(REG_NUM_DATA, ($urandom & ~32'h1FFF) | ph_nd[p]);

			cur_lb = ph_lb[p];
			cur_nd = (ph_nd[p] > MAX_PACKETS) ? MAX_PACKETS : ph_nd[p];

			lsize = 1 << cur_lb;
			nlines = (cur_nd + lsize - 1) >> cur_lb;
			maxe = (ph_maxe[p] < 1) ? 1 : ((ph_maxe[p] > MAX_LINES_HELD) ? MAX_LINES_HELD : ph_maxe[p]);
			hot_cnt = 0;
			if (nlines > 0)
				for (int i = 0; i <= maxe; i++) begin
					hot_lines[hot_cnt] = $urandom_range(nlines - 1);
					hot_cnt++;
				end

			// stall the receiver long enough for the block to back up
			if (p == 0)
				hold_reqs++;

			push_random_cmds(ph_items[p] / 2);
			// on odd phases, drain fully before the second half
			if (p % 2 == 1)
				wait_idle();
			push_random_cmds(ph_items[p] - ph_items[p] / 2);
		end

		wait_idle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
